// ===== hw/rtl/tspr_pkg.sv =====
// shared types and constants for the tcp source port rewriter
`default_nettype none
package tspr_pkg;

	localparam int TableEntriesDef = 64;
	localparam int TcpHdrBytes     = 20;
	localparam int QueueDepth      = 4;

	localparam logic [6:0] OffsetMax    = 7'd127;
	localparam logic [6:0] OffEtypeHi   = 7'd12;
	localparam logic [6:0] OffEtypeLo   = 7'd13;
	localparam logic [6:0] OffVerIhl    = 7'd14;
	localparam logic [6:0] OffProto     = 7'd23;
	localparam logic [6:0] OffDaddrLo   = 7'd30;
	localparam logic [6:0] OffDaddrHi   = 7'd33;
	localparam logic [7:0] EthHdrBytes  = 8'd14;
	localparam logic [7:0] EtypeIpv4Hi  = 8'h08;
	localparam logic [7:0] EtypeIpv4Lo  = 8'h00;
	localparam logic [7:0] ProtoTcp     = 8'd6;
	localparam logic [3:0] MinIhl       = 4'd5;
	localparam logic [4:0] HdrCount     = 5'd20;
	localparam logic [4:0] HdrLastIdx   = 5'd19;

	typedef enum logic [1:0] {
		FS_RUN,
		FS_SCAN,
		FS_DRAIN
	} front_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       changed;
	} item_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] new_port;
	} rule_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tspr_rule_mem.sv =====
// rule table memory with one write port, one registered read port and valid flags
`default_nettype none
module tspr_rule_mem #(
	parameter int TableEntries = tspr_pkg::TableEntriesDef,
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               we,
	input  wire [IdxW-1:0]    waddr,
	input  wire               wvalid,
	input  tspr_pkg::rule_t   wdata,
	input  wire               re,
	input  wire [IdxW-1:0]    raddr,
	output tspr_pkg::rule_t   rdata,
	output logic              rvalid
);

	tspr_pkg::rule_t mem_q [TableEntries];
	logic [TableEntries-1:0] valid_q;
	tspr_pkg::rule_t rdata_q;
	logic rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= wvalid;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tspr_queue.sv =====
// short result queue between the front and the output side
`default_nettype none
module tspr_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             wr,
	input  tspr_pkg::item_t wr_item,
	output logic            is_full,
	output logic            empty,
	input  wire             pop,
	output tspr_pkg::item_t rd_item
);

	localparam int PtrW = $clog2(tspr_pkg::QueueDepth);

	tspr_pkg::item_t slot_q [tspr_pkg::QueueDepth];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [PtrW:0]   cnt_q;
	logic do_wr, do_rd;

	assign is_full = (cnt_q == (PtrW+1)'(tspr_pkg::QueueDepth));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !is_full;
	assign do_rd   = pop && !empty;
	assign rd_item = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tspr_front.sv =====
// frame parser, tcp header holding buffer, rule scan and header release
`default_nettype none
module tspr_front #(
	parameter int TableEntries = tspr_pkg::TableEntriesDef,
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	output logic              full,
	input  wire               action,
	input  wire [7:0]         data_byte,
	input  wire               last_byte,
	input  wire [5:0]         entry_index,
	input  wire               entry_valid,
	input  wire [31:0]        entry_dest_address,
	input  wire [15:0]        entry_dest_port,
	input  wire [15:0]        entry_replacement_port,
	output logic              mem_we,
	output logic [IdxW-1:0]   mem_waddr,
	output logic              mem_wvalid,
	output tspr_pkg::rule_t   mem_wdata,
	output logic              mem_re,
	output logic [IdxW-1:0]   mem_raddr,
	input  tspr_pkg::rule_t   mem_rdata,
	input  wire               mem_rvalid,
	output logic              q_wr,
	output tspr_pkg::item_t   q_item,
	input  wire               q_full
);

	localparam logic [IdxW:0] NumEntries = (IdxW+1)'(TableEntries);
	localparam int ExtW = (IdxW > 6) ? IdxW : 6;

	tspr_pkg::front_state_t state_q, state_n;
	logic [6:0]  off_q;
	logic [3:0]  hw_q, hw_n;
	logic        cand_q, cand_n;
	logic [31:0] addr_q, addr_n;
	logic [4:0]  cnt_q, drain_q;
	logic [7:0]  held_q [tspr_pkg::TcpHdrBytes];
	logic        last_q, hit_q;
	logic [15:0] np_q;
	logic [31:0] key_addr_q;
	logic [IdxW:0] scan_q;
	logic        cmp_vld_s1, cmp_last_s1;
	logic        accept, pkt, hold, hold_done, match, scan_done, drain_end;
	logic [7:0]  tcp_start, off_ext;
	logic [ExtW-1:0] idx_ext;

	assign accept  = push && !full;
	assign pkt     = accept && !action;
	assign off_ext = {1'b0, off_q};

	// header parsing for the current byte
	always_comb begin
		cand_n = cand_q;
		hw_n   = hw_q;
		addr_n = addr_q;
		priority if (off_q == tspr_pkg::OffEtypeHi) begin
			cand_n = (data_byte == tspr_pkg::EtypeIpv4Hi);
		end else if (off_q == tspr_pkg::OffEtypeLo) begin
			cand_n = cand_q && (data_byte == tspr_pkg::EtypeIpv4Lo);
		end else if (off_q == tspr_pkg::OffVerIhl) begin
			hw_n = data_byte[3:0];
			if (hw_n < tspr_pkg::MinIhl) begin
				cand_n = 1'b0;
			end
		end else if (off_q == tspr_pkg::OffProto) begin
			cand_n = cand_q && (data_byte == tspr_pkg::ProtoTcp);
		end else if (off_q >= tspr_pkg::OffDaddrLo && off_q <= tspr_pkg::OffDaddrHi) begin
			addr_n = {addr_q[23:0], data_byte};
		end
	end

	assign tcp_start = tspr_pkg::EthHdrBytes + {2'b00, hw_n, 2'b00};
	assign hold      = cand_n && (off_ext >= tcp_start)
		&& (off_ext < tcp_start + 8'(tspr_pkg::HdrCount))
		&& (cnt_q < tspr_pkg::HdrCount);
	assign hold_done = hold && (cnt_q == tspr_pkg::HdrLastIdx);

	assign match = mem_rvalid && (mem_rdata.addr == key_addr_q)
		&& (mem_rdata.port == {held_q[2], held_q[3]});
	assign scan_done = cmp_vld_s1 && (match || cmp_last_s1);
	assign drain_end = !q_full && (drain_q == cnt_q - 5'd1);

	// rule table writes
	assign idx_ext    = ExtW'(entry_index);
	assign mem_we     = accept && action && ({26'd0, entry_index} < 32'(TableEntries));
	assign mem_waddr  = idx_ext[IdxW-1:0];
	assign mem_wvalid = entry_valid;
	assign mem_wdata  = '{addr: entry_dest_address, port: entry_dest_port,
		new_port: entry_replacement_port};
	assign mem_raddr  = scan_q[IdxW-1:0];

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tspr_pkg::FS_RUN: begin
				if (pkt && hold_done) begin
					state_n = tspr_pkg::FS_SCAN;
				end else if (pkt && hold && last_byte) begin
					state_n = tspr_pkg::FS_DRAIN;
				end
			end
			tspr_pkg::FS_SCAN: begin
				if (scan_done) begin
					state_n = tspr_pkg::FS_DRAIN;
				end
			end
			tspr_pkg::FS_DRAIN: begin
				if (drain_end) begin
					state_n = tspr_pkg::FS_RUN;
				end
			end
			default: state_n = tspr_pkg::FS_RUN;
		endcase
	end

	always_comb begin
		full   = 1'b1;
		q_wr   = 1'b0;
		q_item = '{data: data_byte, last: last_byte, changed: 1'b0};
		mem_re = 1'b0;
		unique case (state_q)
			tspr_pkg::FS_RUN: begin
				full = q_full;
				q_wr = pkt && !hold;
			end
			tspr_pkg::FS_SCAN: begin
				mem_re = (scan_q < NumEntries);
			end
			tspr_pkg::FS_DRAIN: begin
				q_wr = 1'b1;
				q_item.data = held_q[drain_q];
				if (hit_q && drain_q == 5'd0) begin
					q_item.data = np_q[15:8];
				end else if (hit_q && drain_q == 5'd1) begin
					q_item.data = np_q[7:0];
				end
				q_item.last    = last_q && (drain_q == cnt_q - 5'd1);
				q_item.changed = hit_q && (drain_q < 5'd2);
			end
			default: begin
				full = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == tspr_pkg::FS_RUN && pkt && hold) begin
			held_q[cnt_q] <= data_byte;
		end
		if (state_q == tspr_pkg::FS_RUN && pkt && hold_done) begin
			key_addr_q <= addr_n;
		end
		if (state_q == tspr_pkg::FS_SCAN && scan_done) begin
			np_q <= mem_rdata.new_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tspr_pkg::FS_RUN;
			off_q       <= '0;
			hw_q        <= '0;
			cand_q      <= 1'b0;
			addr_q      <= '0;
			cnt_q       <= '0;
			drain_q     <= '0;
			last_q      <= 1'b0;
			hit_q       <= 1'b0;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				tspr_pkg::FS_RUN: begin
					if (pkt) begin
						if (hold) begin
							cnt_q  <= cnt_q + 5'd1;
							last_q <= last_byte;
						end
						if (last_byte) begin
							off_q  <= '0;
							hw_q   <= '0;
							cand_q <= 1'b0;
							addr_q <= '0;
						end else begin
							off_q  <= (off_q < tspr_pkg::OffsetMax) ? off_q + 7'd1 : off_q;
							hw_q   <= hw_n;
							cand_q <= cand_n;
							addr_q <= addr_n;
						end
					end
					scan_q     <= '0;
					cmp_vld_s1 <= 1'b0;
					hit_q      <= 1'b0;
					drain_q    <= '0;
				end
				tspr_pkg::FS_SCAN: begin
					if (mem_re) begin
						scan_q <= scan_q + 1'b1;
					end
					cmp_vld_s1  <= mem_re;
					cmp_last_s1 <= (scan_q == NumEntries - 1'b1);
					if (scan_done) begin
						hit_q <= match;
					end
				end
				tspr_pkg::FS_DRAIN: begin
					if (!q_full) begin
						drain_q <= drain_q + 5'd1;
					end
					if (drain_end) begin
						cnt_q <= '0;
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tcp_source_port_rewriter_core.sv =====
// top level of the tcp source port rewriter
// Frame bytes and rule writes enter through one queue-style port (push/full)
// and rewritten bytes leave through another (empty/pop). Ordinary bytes and
// rule writes are taken one per cycle while the queue has room. For an IPv4/TCP
// frame the 20 TCP header bytes are held; when the header is complete the input
// stalls while the rule memory is scanned one entry per cycle through its single
// read port (lowest index first, ending early on a hit), then the header goes
// out one byte per cycle while the queue has room, with the source port replaced
// on a hit. A frame that ends inside the TCP header releases its held bytes
// unchanged in the same way. The TCP checksum is left as it is.
`default_nettype none
module tcp_source_port_rewriter_core #(
	parameter int TABLE_ENTRIES = tspr_pkg::TableEntriesDef
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire        action,
	input  wire [7:0]  data_byte,
	input  wire        last_byte,
	input  wire [5:0]  entry_index,
	input  wire        entry_valid,
	input  wire [31:0] entry_dest_address,
	input  wire [15:0] entry_dest_port,
	input  wire [15:0] entry_replacement_port,
	output logic       empty,
	input  wire        pop,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_changed
);

	localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic            mem_we, mem_wvalid, mem_re, mem_rvalid;
	logic [IdxW-1:0] mem_waddr, mem_raddr;
	tspr_pkg::rule_t mem_wdata, mem_rdata;
	logic            q_wr, q_full;
	tspr_pkg::item_t q_item, rd_item;

	tspr_front #(.TableEntries(TABLE_ENTRIES)) u_front (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.push                   (push),
		.full                   (full),
		.action                 (action),
		.data_byte              (data_byte),
		.last_byte              (last_byte),
		.entry_index            (entry_index),
		.entry_valid            (entry_valid),
		.entry_dest_address     (entry_dest_address),
		.entry_dest_port        (entry_dest_port),
		.entry_replacement_port (entry_replacement_port),
		.mem_we                 (mem_we),
		.mem_waddr              (mem_waddr),
		.mem_wvalid             (mem_wvalid),
		.mem_wdata              (mem_wdata),
		.mem_re                 (mem_re),
		.mem_raddr              (mem_raddr),
		.mem_rdata              (mem_rdata),
		.mem_rvalid             (mem_rvalid),
		.q_wr                   (q_wr),
		.q_item                 (q_item),
		.q_full                 (q_full)
	);

	tspr_rule_mem #(.TableEntries(TABLE_ENTRIES)) u_rule_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wvalid (mem_wvalid),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata),
		.rvalid (mem_rvalid)
	);

	tspr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (q_item),
		.is_full (q_full),
		.empty   (empty),
		.pop     (pop),
		.rd_item (rd_item)
	);

	assign out_byte    = rd_item.data;
	assign out_last    = rd_item.last;
	assign out_changed = rd_item.changed;

endmodule
`default_nettype wire
